[sv/mimo_block_fir_convolver_core_macros.svh]
// Assertion macros shared by the convolver core.
`ifndef MIMO_BLOCK_FIR_CONVOLVER_CORE_MACROS_SVH
`define MIMO_BLOCK_FIR_CONVOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define MBFC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbfc assertion failed");

// Next-cycle implication, checked on clk outside of reset.
`define MBFC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbfc assertion failed");

`endif

[sv/mbfc_pkg.sv]
// Types and constants shared by the convolver core modules.
package mbfc_pkg;

    localparam int SAMPLE_BITS = 24;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_PULL = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_PULL = 2'd1,
        CMD_LOAD = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        REG_BLOCK_LOG2   = 3'd0,
        REG_INPUTS       = 3'd1,
        REG_OUTPUTS      = 3'd2,
        REG_RESP_LENGTH  = 3'd3,
        REG_OUTPUT_GAIN  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [23:0] sample;
        logic               coef_output;
        logic [6:0]         coef_input;
        logic [9:0]         coef_tap;
        logic signed [23:0] coef_value;
    } cmd_t;

    // Clamped working configuration.
    typedef struct packed {
        logic [10:0] blk;
        logic [7:0]  nin;
        logic [3:0]  nout;
        logic [13:0] taps;
        logic [15:0] gain;
    } cfg_t;

    typedef struct packed {
        logic               valid_res;
        logic signed [23:0] out_sample;
        logic               out_channel;
        logic [7:0]         frame_index;
        logic               last_of_block;
    } res_t;

    localparam logic signed [63:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;
    localparam logic signed [45:0] OUT_MAX   = 46'sd8388607;
    localparam logic signed [45:0] OUT_MIN   = -46'sd8388608;

endpackage

[sv/mbfc_front.sv]
// Front end: accepts stream requests and decodes them into commands.
module mbfc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output mbfc_pkg::cmd_t      cmd
);
    import mbfc_pkg::*;

    logic full_reg;
    cmd_t cmd_reg;
    cmd_t dec;
    logic keep;
    logic take;

    assign s_tready  = !full_reg || cmd_ready;
    assign take      = s_tvalid && s_tready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        dec.sample      = s_tdata[23:0];
        dec.coef_output = s_tdata[24];
        dec.coef_input  = s_tdata[31:25];
        dec.coef_tap    = s_tdata[41:32];
        dec.coef_value  = s_tdata[65:42];
        keep            = 1'b1;
        case (s_tuser)
            MODE_PUSH: dec.kind = CMD_PUSH;
            MODE_PULL: dec.kind = CMD_PULL;
            MODE_LOAD: dec.kind = CMD_LOAD;
            default:
            begin
                // The unused mode is taken and dropped.
                dec.kind = CMD_PUSH;
                keep     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            full_reg <= keep;
        end
        else if (cmd_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= dec;
        end
    end

endmodule

[sv/mbfc_queue.sv]
// Two-entry command queue between the front end and the engine.
module mbfc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mbfc_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output mbfc_pkg::cmd_t out_cmd
);
    import mbfc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_cmd   = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

[sv/mbfc_back.sv]
// Engine: history and coefficient stores, block MAC pipeline and readout.
module mbfc_back
#(
    parameter int MAX_INPUTS  = 84,
    parameter int MAX_OUTPUTS = 2,
    parameter int MAX_TAPS    = 1024,
    parameter int MAX_BLOCK   = 256
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  mbfc_pkg::cfg_t cfg,
    input  logic           clear,
    input  logic           q_valid,
    output logic           q_ready,
    input  mbfc_pkg::cmd_t q_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output mbfc_pkg::res_t res
);
    import mbfc_pkg::*;

    localparam int HIST   = MAX_TAPS + MAX_BLOCK;
    localparam int HW     = $clog2(HIST);
    localparam int IW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OW     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int TW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int BW     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int ODEPTH = MAX_OUTPUTS * MAX_BLOCK;
    localparam int OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
    localparam int UW     = $clog2(ODEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_CALC  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic signed [23:0] hist_mem [MAX_INPUTS][HIST];
    logic signed [23:0] coef_mem [MAX_OUTPUTS][MAX_INPUTS][MAX_TAPS];
    logic signed [23:0] out_mem  [ODEPTH];

    // Stream position.
    logic [IW-1:0] ch_reg;
    logic [HW-1:0] hpos_reg;
    logic [HW:0]   fill_reg;
    logic [BW:0]   pfr_reg;

    // Block loop counters.
    logic [BW-1:0] cf_reg;
    logic [OW-1:0] co_reg;
    logic [IW-1:0] cc_reg;
    logic [TW-1:0] ck_reg;
    logic [HW-1:0] posf_reg;
    logic [HW-1:0] ridx_reg;
    logic [HW:0]   avail_reg;
    logic [UW-1:0] wr_ptr_reg;

    // MAC pipeline.
    logic               v1_reg, first1_reg, last1_reg, mask1_reg;
    logic signed [23:0] h_q, c_q;
    logic               v2_reg, first2_reg, last2_reg;
    logic signed [47:0] prod_reg;
    logic               f3_reg;
    logic signed [63:0] acc_reg;
    logic               f4_reg;
    logic signed [40:0] s_reg;
    logic               f5_reg;
    logic signed [57:0] g_reg;

    // Readout.
    logic [UW-1:0] rd_ptr_reg;
    logic [UW-1:0] unread_reg;
    logic [OW-1:0] rd_ch_reg;
    logic [BW-1:0] rd_fr_reg;
    logic          pend_reg;
    res_t          pend_meta_reg;
    logic signed [23:0] o_q;
    logic          mvalid_reg;
    res_t          res_reg;

    logic pop, do_push, do_pull, do_load;
    logic ch_last, frame_done, block_done;
    logic ck_last, cc_last, co_last, cf_last;
    logic pipe_busy;
    logic signed [47:0] mul;
    logic signed [63:0] acc_sum, acc_base;
    logic signed [63:0] rnd;
    logic signed [57:0] gp, gr;
    logic signed [45:0] gq;
    logic signed [23:0] outv;
    logic [HW:0] pos_tmp;
    logic load_ok;

    assign m_valid = mvalid_reg;
    assign res     = res_reg;

    always_comb
    begin
        q_ready = 1'b0;
        if (state_reg == S_IDLE && !clear)
        begin
            q_ready = (q_cmd.kind != CMD_PULL) || (!pend_reg && !mvalid_reg);
        end
    end

    assign pop     = q_valid && q_ready;
    assign do_push = pop && q_cmd.kind == CMD_PUSH;
    assign do_pull = pop && q_cmd.kind == CMD_PULL;
    assign do_load = pop && q_cmd.kind == CMD_LOAD;

    assign ch_last    = (8'(ch_reg) + 8'd1) >= cfg.nin;
    assign frame_done = do_push && ch_last;
    assign block_done = frame_done && (11'(pfr_reg) + 11'd1) >= cfg.blk;

    assign ck_last = 14'(ck_reg) == cfg.taps - 14'd1;
    assign cc_last = 8'(cc_reg) == cfg.nin - 8'd1;
    assign co_last = 4'(co_reg) == cfg.nout - 4'd1;
    assign cf_last = 11'(cf_reg) == cfg.blk - 11'd1;

    assign pipe_busy = v1_reg || v2_reg || f3_reg || f4_reg || f5_reg;

    assign load_ok = (32'(q_cmd.coef_output) < MAX_OUTPUTS)
                  && (32'(q_cmd.coef_input) < MAX_INPUTS)
                  && (32'(q_cmd.coef_tap) < MAX_TAPS);

    always_comb
    begin
        pos_tmp = (HW+1)'(hpos_reg) + (HW+1)'(HIST) - (HW+1)'(cfg.blk);
        if (pos_tmp >= (HW+1)'(HIST))
        begin
            pos_tmp = pos_tmp - (HW+1)'(HIST);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (block_done) state_next = S_SETUP;
            S_SETUP: state_next = S_CALC;
            S_CALC:  if (ck_last && cc_last && co_last && cf_last) state_next = S_DRAIN;
            S_DRAIN: if (!pipe_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: engine, stream position and readout.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ch_reg     <= '0;
            hpos_reg   <= '0;
            fill_reg   <= '0;
            pfr_reg    <= '0;
            rd_ptr_reg <= '0;
            unread_reg <= '0;
            rd_ch_reg  <= '0;
            rd_fr_reg  <= '0;
            pend_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                ch_reg     <= '0;
                hpos_reg   <= '0;
                fill_reg   <= '0;
                pfr_reg    <= '0;
                rd_ptr_reg <= '0;
                unread_reg <= '0;
                rd_ch_reg  <= '0;
                rd_fr_reg  <= '0;
            end
            else if (do_push)
            begin
                if (ch_last)
                begin
                    ch_reg   <= '0;
                    hpos_reg <= (hpos_reg == HW'(HIST - 1)) ? '0 : hpos_reg + 1'b1;
                    if (fill_reg < (HW+1)'(HIST))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    pfr_reg <= block_done ? '0 : pfr_reg + 1'b1;
                end
                else
                begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
            else if (do_pull && unread_reg != '0)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                unread_reg <= unread_reg - 1'b1;
                if (4'(rd_ch_reg) + 4'd1 >= cfg.nout)
                begin
                    rd_ch_reg <= '0;
                    rd_fr_reg <= rd_fr_reg + 1'b1;
                end
                else
                begin
                    rd_ch_reg <= rd_ch_reg + 1'b1;
                end
            end
            else if (state_reg == S_DRAIN && !pipe_busy)
            begin
                // New block replaces whatever was still unread.
                rd_ptr_reg <= '0;
                unread_reg <= wr_ptr_reg;
                rd_ch_reg  <= '0;
                rd_fr_reg  <= '0;
            end

            pend_reg <= do_pull && unread_reg != '0;
            if (mvalid_reg && m_ready)
            begin
                mvalid_reg <= 1'b0;
            end
            else if (pend_reg || (do_pull && unread_reg == '0))
            begin
                mvalid_reg <= 1'b1;
            end
        end
    end

    // Result register and readout metadata.
    always_ff @(posedge clk)
    begin
        if (do_pull)
        begin
            pend_meta_reg.valid_res     <= 1'b1;
            pend_meta_reg.out_sample    <= '0;
            pend_meta_reg.out_channel   <= rd_ch_reg[0];
            pend_meta_reg.frame_index   <= 8'(rd_fr_reg);
            pend_meta_reg.last_of_block <= unread_reg == UW'(1);
            if (unread_reg == '0)
            begin
                res_reg <= '0;
            end
        end
        if (pend_reg)
        begin
            res_reg            <= pend_meta_reg;
            res_reg.out_sample <= o_q;
        end
    end

    // Loop counters of the block computation.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SETUP)
        begin
            cf_reg     <= '0;
            co_reg     <= '0;
            cc_reg     <= '0;
            ck_reg     <= '0;
            posf_reg   <= HW'(pos_tmp);
            ridx_reg   <= HW'(pos_tmp);
            avail_reg  <= fill_reg - (HW+1)'(cfg.blk);
            wr_ptr_reg <= '0;
        end
        else
        begin
            if (state_reg == S_CALC)
            begin
                if (!ck_last)
                begin
                    ck_reg   <= ck_reg + 1'b1;
                    ridx_reg <= (ridx_reg == '0) ? HW'(HIST - 1) : ridx_reg - 1'b1;
                end
                else
                begin
                    ck_reg   <= '0;
                    ridx_reg <= posf_reg;
                    if (!cc_last)
                    begin
                        cc_reg <= cc_reg + 1'b1;
                    end
                    else
                    begin
                        cc_reg <= '0;
                        if (!co_last)
                        begin
                            co_reg <= co_reg + 1'b1;
                        end
                        else
                        begin
                            co_reg    <= '0;
                            cf_reg    <= cf_reg + 1'b1;
                            avail_reg <= avail_reg + 1'b1;
                            posf_reg  <= (posf_reg == HW'(HIST - 1)) ? '0 : posf_reg + 1'b1;
                            ridx_reg  <= (posf_reg == HW'(HIST - 1)) ? '0 : posf_reg + 1'b1;
                        end
                    end
                end
            end
            if (f5_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f3_reg <= 1'b0;
            f4_reg <= 1'b0;
            f5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= state_reg == S_CALC;
            v2_reg <= v1_reg;
            f3_reg <= v2_reg && last2_reg;
            f4_reg <= f3_reg;
            f5_reg <= f4_reg;
        end
    end

    always_comb
    begin
        mul      = h_q * c_q;
        acc_base = first2_reg ? 64'sd0 : acc_reg;
        acc_sum  = acc_base + 64'(prod_reg);
        if (acc_sum > ACC_LIMIT)
        begin
            acc_sum = ACC_LIMIT;
        end
        else if (acc_sum < -ACC_LIMIT)
        begin
            acc_sum = -ACC_LIMIT;
        end
        rnd = acc_reg + 64'sd4194304;
        gp  = s_reg * $signed({1'b0, cfg.gain});
        gr  = g_reg + 58'sd2048;
        gq  = 46'(gr >>> 12);
        if (gq > OUT_MAX)
        begin
            outv = 24'(OUT_MAX);
        end
        else if (gq < OUT_MIN)
        begin
            outv = 24'(OUT_MIN);
        end
        else
        begin
            outv = 24'(gq);
        end
    end

    // Pipeline data path.
    always_ff @(posedge clk)
    begin
        first1_reg <= cc_reg == '0 && ck_reg == '0;
        last1_reg  <= cc_last && ck_last;
        mask1_reg  <= (HW+1)'(ck_reg) <= avail_reg;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        prod_reg   <= mask1_reg ? mul : 48'sd0;
        if (v2_reg)
        begin
            acc_reg <= acc_sum;
        end
        s_reg <= 41'(rnd >>> 23);
        g_reg <= gp;
    end

    // History store.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            hist_mem[ch_reg][hpos_reg] <= q_cmd.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        h_q <= hist_mem[cc_reg][ridx_reg];
    end

    // Coefficient store.
    always_ff @(posedge clk)
    begin
        if (do_load && load_ok)
        begin
            coef_mem[OW'(q_cmd.coef_output)][IW'(q_cmd.coef_input)][TW'(q_cmd.coef_tap)]
                <= q_cmd.coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        c_q <= coef_mem[co_reg][cc_reg][ck_reg];
    end

    // Output block store.
    always_ff @(posedge clk)
    begin
        if (f5_reg)
        begin
            out_mem[wr_ptr_reg[OAW-1:0]] <= outv;
        end
    end

    always_ff @(posedge clk)
    begin
        o_q <= out_mem[rd_ptr_reg[OAW-1:0]];
    end

endmodule

[sv/mimo_block_fir_convolver_core.sv]
// Top level of the matrix FIR convolver: registers, front end, queue, engine.
//
//  Channel   Dir  Handshake         Contents
//  s_*       in   tvalid/tready     push sample, pull, or coefficient load request
//  m_*       out  tvalid/tready     one result per pull request
//  APB       in   psel/penable      five configuration registers at 4*i
//
// The push that completes a block starts the computation, which runs one
// multiply-accumulate per cycle through a single pipelined MAC fed by the
// history and coefficient memories. No request is taken by the engine while a
// block is computed; the queue and the result register let each side stall on
// its own. Reset is asynchronous and active low; the memories need no clearing
// since a fill count masks history that was never written since the last reset
// or structural write.
module mimo_block_fir_convolver_core
#(
    parameter int MAX_INPUTS  = 84,
    parameter int MAX_OUTPUTS = 2,
    parameter int MAX_TAPS    = 1024,
    parameter int MAX_BLOCK   = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample[23:0], coef_output[24], coef_input[31:25], coef_tap[41:32],
    // coef_value[65:42], zero fill [71:66]
    input  logic [71:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_sample[23:0], out_channel[24], frame_index[32:25], zero fill [39:33]
    output logic [39:0] m_tdata,
    // valid_res[0]
    output logic        m_tuser,
    // last_of_block
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbfc_pkg::*;

`include "mimo_block_fir_convolver_core_macros.svh"

    logic [3:0]  blk_log2_reg;
    logic [6:0]  inputs_reg;
    logic [1:0]  outputs_reg;
    logic [10:0] resp_len_reg;
    logic [15:0] gain_reg;

    logic     wr_en;
    reg_idx_t wr_idx;
    logic     clear;
    cfg_t     cfg;
    logic [16:0] blk_full;

    logic cmd_valid, cmd_ready, q_valid, q_ready;
    cmd_t cmd, q_cmd;
    res_t res;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[4:2]);

    // Structural registers restart the stream; the gain does not.
    assign clear = wr_en && (wr_idx == REG_BLOCK_LOG2 || wr_idx == REG_INPUTS
                          || wr_idx == REG_OUTPUTS || wr_idx == REG_RESP_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_log2_reg <= 4'd6;
            inputs_reg   <= 7'd84;
            outputs_reg  <= 2'd2;
            resp_len_reg <= 11'd1024;
            gain_reg     <= 16'd4096;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_BLOCK_LOG2:  blk_log2_reg <= pwdata[3:0];
                REG_INPUTS:      inputs_reg   <= pwdata[6:0];
                REG_OUTPUTS:     outputs_reg  <= pwdata[1:0];
                REG_RESP_LENGTH: resp_len_reg <= pwdata[10:0];
                REG_OUTPUT_GAIN: gain_reg     <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_BLOCK_LOG2:  prdata = 32'(blk_log2_reg);
            REG_INPUTS:      prdata = 32'(inputs_reg);
            REG_OUTPUTS:     prdata = 32'(outputs_reg);
            REG_RESP_LENGTH: prdata = 32'(resp_len_reg);
            REG_OUTPUT_GAIN: prdata = 32'(gain_reg);
            default:         prdata = '0;
        endcase
    end

    // Clamp the registers to the sizes the stores were built for.
    always_comb
    begin
        blk_full = 17'd1 << blk_log2_reg;
        cfg.blk  = (blk_full > 17'(MAX_BLOCK)) ? 11'(MAX_BLOCK) : 11'(blk_full);
        if (inputs_reg == '0)
            cfg.nin = 8'd1;
        else if (8'(inputs_reg) > 8'(MAX_INPUTS))
            cfg.nin = 8'(MAX_INPUTS);
        else
            cfg.nin = 8'(inputs_reg);
        if (outputs_reg == '0)
            cfg.nout = 4'd1;
        else if (4'(outputs_reg) > 4'(MAX_OUTPUTS))
            cfg.nout = 4'(MAX_OUTPUTS);
        else
            cfg.nout = 4'(outputs_reg);
        if (resp_len_reg == '0)
            cfg.taps = 14'd1;
        else if (14'(resp_len_reg) > 14'(MAX_TAPS))
            cfg.taps = 14'(MAX_TAPS);
        else
            cfg.taps = 14'(resp_len_reg);
        cfg.gain = gain_reg;
    end

    mbfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mbfc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_cmd    (cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mbfc_back
    #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .MAX_TAPS    (MAX_TAPS),
        .MAX_BLOCK   (MAX_BLOCK)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .clear   (clear),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .res     (res)
    );

    assign m_tdata = {7'd0, res.frame_index, res.out_channel, res.out_sample};
    assign m_tuser = res.valid_res;
    assign m_tlast = res.last_of_block;

    // The end of a block is only ever flagged on a real sample.
    `MBFC_ASSERT_IMP(a_last_is_valid, m_tvalid && m_tlast, m_tuser)
    // A pull that found nothing unread returns all zero fields.
    `MBFC_ASSERT_IMP(a_empty_is_zero, m_tvalid && !m_tuser, m_tdata == '0)
    // A gain write lands in the register on the write edge.
    `MBFC_ASSERT_NXT(a_gain_write, wr_en && paddr[4:2] == 3'(REG_OUTPUT_GAIN), gain_reg == $past(pwdata[15:0]))

endmodule
